// File: rtl/dbbp_pkg.sv
// ----------------------------------------------------------------------------
// dbbp_pkg: shared definitions of the delta block bit packer
// Sizes, code bytes, controller states and the command and status groups
// that join the controller, the datapath and the result assembler.
// ----------------------------------------------------------------------------
package dbbp_pkg;

  localparam int WINDOW_DEPTH    = 64;
  localparam int WIN_AW          = $clog2(WINDOW_DEPTH);
  localparam int FILL_W          = WIN_AW + 1;
  localparam int LITERAL_RUN_MAX = 16;
  localparam int MAX_BLOCK_BITS  = 32;
  localparam int RUN_COUNT_BITS  = 32;
  localparam int ZERO_RUN_MIN    = 16;
  localparam int RES_BYTES       = 64;
  localparam int CNT_W           = 7;
  localparam int BW_W            = $clog2(MAX_BLOCK_BITS + 1);
  localparam int SH_W            = $clog2(MAX_BLOCK_BITS);
  localparam int NUM_SIZES       = 4;

  localparam logic [7:0] BYTE_ZERO_RUN = 8'hFE;
  localparam logic [7:0] BYTE_LITERAL  = 8'hFF;
  localparam logic [7:0] BYTE_ABSENT   = 8'hFD;

  typedef enum logic [1:0] {
    DK_ZR_ENTER,
    DK_ZERO,
    DK_BLOCK,
    DK_LITERAL
  } dec_kind_t;

  typedef enum logic [2:0] {
    BS_ZERO_RUN,
    BS_ABSENT,
    BS_LITERAL,
    BS_BLK_HDR,
    BS_LIT_LEN,
    BS_ULEB,
    BS_ROW
  } byte_src_t;

  typedef enum logic [1:0] {
    UL_ABSENT,
    UL_ZRUN,
    UL_ZERO,
    UL_LIT
  } uleb_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_SCAN,
    ST_DECIDE,
    ST_ZR_HDR,
    ST_AR_HDR,
    ST_ZERO_HDR,
    ST_ULEB,
    ST_BLK_HDR,
    ST_BLK_ROW,
    ST_LIT_HDR,
    ST_LIT_LEN,
    ST_LIT_RD,
    ST_LIT_LD
  } state_t;

  typedef enum logic [1:0] {
    PH_ABS,
    PH_PRES,
    PH_LAST,
    PH_OUT
  } phase_t;

  typedef struct packed {
    logic      item_load;
    logic      push;
    byte_src_t byte_src;
    logic      uleb_load;
    uleb_src_t uleb_src;
    logic      write;
    logic      scan_clear;
    logic      scan_run;
    logic      open;
    logic      decide;
    logic      zr_enter;
    logic      zr_clear;
    logic      zr_inc;
    logic      ar_clear;
    logic      ar_count;
    logic      drop;
    logic      blk_init;
    logic      rd_lit;
    logic      lit_clear;
    logic      lit_next;
    logic      flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic      fill_zero;
    logic      fill_last;
    logic      in_zr;
    logic      in_ar;
    logic      value_zero;
    logic      scan_done;
    dec_kind_t kind;
    logic      uleb_last;
    logic      blk_last;
    logic      lit_done;
  } dp_status_t;

  typedef struct packed {
    logic byte_ready;
    logic flush_ok;
  } asm_status_t;

endpackage

// File: rtl/dbbp_if.sv
// ----------------------------------------------------------------------------
// dbbp_in_if / dbbp_out_if: request channels of the delta block bit packer
// Valid/ready channels carrying one input observation and one result.
// ----------------------------------------------------------------------------
interface dbbp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        absent;
  logic        last;

  modport source (output valid, output value, output absent, output last, input ready);
  modport sink   (input valid, input value, input absent, input last, output ready);
endinterface

interface dbbp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] word_0;
  logic [63:0] word_1;
  logic [63:0] word_2;
  logic [63:0] word_3;
  logic [63:0] word_4;
  logic [63:0] word_5;
  logic [63:0] word_6;
  logic [63:0] word_7;
  logic [6:0]  byte_count;
  logic        burst_end;

  modport source (
    output valid, output word_0, output word_1, output word_2, output word_3,
    output word_4, output word_5, output word_6, output word_7,
    output byte_count, output burst_end, input ready
  );
  modport sink (
    input valid, input word_0, input word_1, input word_2, input word_3,
    input word_4, input word_5, input word_6, input word_7,
    input byte_count, input burst_end, output ready
  );
endinterface

// File: rtl/delta_block_bit_packer.sv
// ----------------------------------------------------------------------------
// delta_block_bit_packer: streaming zigzag LEB128 / bit-plane delta coder
// Each window decision scans the window, decides the coding and emits the coded
// bytes, reading each literal back from the window; a run header emits its code
// byte and then its LEB128 count bytes. Bytes stall while a full result waits on
// the sink.
// Reset (synchronous, rst high) empties the window and clears both run counts.
// ----------------------------------------------------------------------------
module delta_block_bit_packer
  import dbbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  dbbp_in_if.sink    item,
  dbbp_out_if.source result
);

  // The controller sequences each request; the datapath owns the window
  // ring, the decision scan and every byte source; the assembler packs bytes
  // into 64-byte results and keeps one finished result so that a new
  // request can be taken while the previous one waits on the sink.
  ctrl_cmd_t   cmd;
  dp_status_t  dp_st;
  asm_status_t asm_st;
  logic [7:0]  coded_byte;

  dbbp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item.valid),
    .item_absent (item.absent),
    .item_last   (item.last),
    .item_ready  (item.ready),
    .dp          (dp_st),
    .asm_st      (asm_st),
    .cmd         (cmd)
  );

  dbbp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .value_in (item.value),
    .status   (dp_st),
    .byte_out (coded_byte)
  );

  // The final result of each request carries burst_end; a request that
  // codes no bytes gives no result.
  dbbp_out_asm u_out_asm (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd.push),
    .byte_in (coded_byte),
    .flush   (cmd.flush),
    .status  (asm_st),
    .result  (result)
  );

endmodule

// File: rtl/dbbp_out_asm.sv
// ----------------------------------------------------------------------------
// dbbp_out_asm: result assembler
// Collects coded bytes into 64-byte results and holds one finished result
// in an output register until the sink takes it.
// ----------------------------------------------------------------------------
module dbbp_out_asm
  import dbbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        byte_in,
  input  logic              flush,
  output asm_status_t       status,
  dbbp_out_if.source        result
);

  logic [RES_BYTES*8-1:0] buf_q;
  logic [CNT_W-1:0]       cnt;
  logic [RES_BYTES*8-1:0] obuf;
  logic [CNT_W-1:0]       ocount;
  logic                   oend;
  logic                   ovalid;
  logic                   full;

  assign full              = (cnt == CNT_W'(RES_BYTES));
  assign status.byte_ready = !(full && ovalid);
  assign status.flush_ok   = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      ovalid <= 1'b0;
      buf_q  <= '0;
    end else begin
      if (ovalid && result.ready) begin
        ovalid <= 1'b0;
      end
      if (push) begin
        if (full) begin
          obuf   <= buf_q;
          ocount <= cnt;
          oend   <= 1'b0;
          ovalid <= 1'b1;
          buf_q  <= {{(RES_BYTES*8-8){1'b0}}, byte_in};
          cnt    <= CNT_W'(1);
        end else begin
          buf_q[{cnt[CNT_W-2:0], 3'b000} +: 8] <= byte_in;
          cnt <= cnt + CNT_W'(1);
        end
      end else if (flush && cnt != '0) begin
        obuf   <= buf_q;
        ocount <= cnt;
        oend   <= 1'b1;
        ovalid <= 1'b1;
        buf_q  <= '0;
        cnt    <= '0;
      end
    end
  end

  assign result.valid      = ovalid;
  assign result.word_0     = obuf[63:0];
  assign result.word_1     = obuf[127:64];
  assign result.word_2     = obuf[191:128];
  assign result.word_3     = obuf[255:192];
  assign result.word_4     = obuf[319:256];
  assign result.word_5     = obuf[383:320];
  assign result.word_6     = obuf[447:384];
  assign result.word_7     = obuf[511:448];
  assign result.byte_count = ocount;
  assign result.burst_end  = oend;

endmodule

// File: rtl/dbbp_datapath.sv
// ----------------------------------------------------------------------------
// dbbp_datapath: window memory, scan unit, block planes and byte sources
// Holds the value window as a ring, scans it for the coding decision,
// keeps the run counters and forms each coded byte.
// ----------------------------------------------------------------------------
module dbbp_datapath
  import dbbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  input  logic [63:0] value_in,
  output dp_status_t  status,
  output logic [7:0]  byte_out
);

  logic [63:0]               mem [WINDOW_DEPTH];
  logic [63:0]               rdata;
  logic [WIN_AW-1:0]         head;
  logic [FILL_W-1:0]         fill;
  logic [63:0]               value_q;

  logic [FILL_W-1:0]         ri;
  logic [FILL_W-1:0]         pc;
  logic                      pend_v;
  logic [WIN_AW-1:0]         pend_i;
  logic                      zpref;
  logic [FILL_W-1:0]         zcnt;
  logic [63:0]               or_acc;
  logic [NUM_SIZES-1:0]      snap_hi;
  logic [BW_W-1:0]           snap_bw [NUM_SIZES];
  logic [WINDOW_DEPTH-1:0]   plane [MAX_BLOCK_BITS];

  dec_kind_t                 dk;
  logic [1:0]                dci;
  logic [BW_W-1:0]           dbw;
  logic [FILL_W-1:0]         dz;
  logic [FILL_W-1:0]         dlit;

  logic [SH_W-1:0]           blk_sh;
  logic [2:0]                blk_by;
  logic [2:0]                bpr_m1;

  logic [63:0]               uleb_q;
  logic [FILL_W-1:0]         li;

  logic                      in_zr;
  logic [RUN_COUNT_BITS-1:0] zc;
  logic                      in_ar;
  logic [RUN_COUNT_BITS-1:0] ac;

  logic                      issue;
  logic [WIN_AW-1:0]         rd_addr;
  logic [63:0]               mag;
  logic [63:0]               or_n;

  dec_kind_t                 kind_now;
  logic                      best_found;
  logic [1:0]                best_c;
  logic [BW_W-1:0]           best_bw;
  logic [FILL_W-1:0]         lit_k;
  logic [FILL_W-1:0]         drop_amt;
  logic [63:0]               uleb_src_val;
  logic [7:0]                row_byte;

  // Two's complement width of a value whose sign has been folded away.
  function automatic logic [BW_W-1:0] tc_bits(input logic [MAX_BLOCK_BITS-2:0] v);
    logic [BW_W-1:0] n;
    n = BW_W'(1);
    for (int i = 0; i < MAX_BLOCK_BITS - 1; i++) begin
      if (v[i]) n = BW_W'(i + 2);
    end
    return n;
  endfunction

  assign issue   = cmd.scan_run && (ri < fill);
  assign rd_addr = head + (cmd.rd_lit ? li[WIN_AW-1:0] : ri[WIN_AW-1:0]);
  assign mag     = rdata ^ {64{rdata[63]}};
  assign or_n    = or_acc | mag;

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[head + fill[WIN_AW-1:0]] <= value_q;
    end
    rdata <= mem[rd_addr];
  end

  // Scan: one read issued per cycle, its data processed in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else begin
      pend_v <= issue;
    end
    pend_i <= ri[WIN_AW-1:0];
    if (cmd.scan_clear) begin
      ri     <= '0;
      pc     <= '0;
      zpref  <= 1'b1;
      zcnt   <= '0;
      or_acc <= '0;
    end else begin
      if (issue) ri <= ri + FILL_W'(1);
      if (pend_v) begin
        pc     <= pc + FILL_W'(1);
        or_acc <= or_n;
        if (zpref && rdata == 64'd0) begin
          zcnt <= zcnt + FILL_W'(1);
        end else begin
          zpref <= 1'b0;
        end
        for (int c = 0; c < NUM_SIZES; c++) begin
          if (pend_i == WIN_AW'((8 << c) - 1)) begin
            snap_hi[c] <= |or_n[63:MAX_BLOCK_BITS-1];
            snap_bw[c] <= tc_bits(or_n[MAX_BLOCK_BITS-2:0]);
          end
        end
        for (int b = 0; b < MAX_BLOCK_BITS; b++) begin
          plane[b][pend_i] <= rdata[b];
        end
      end
    end
  end

  // Block size pick: least bytes per value, first size wins a tie.
  always_comb begin
    logic [15:0]       cost_c;
    logic [15:0]       pick_cost;
    logic [FILL_W:0]   m_c;
    logic              ok;
    best_found = 1'b0;
    best_c     = 2'd0;
    best_bw    = '0;
    pick_cost  = '0;
    for (int c = 0; c < NUM_SIZES; c++) begin
      m_c    = (FILL_W + 1)'(8 << c);
      cost_c = 16'd8 + (16'(snap_bw[c]) << (3 + c));
      ok     = ({1'b0, fill} >= m_c) && !snap_hi[c];
      if (ok && (!best_found ||
                 ((cost_c << best_c) < (pick_cost << c)))) begin
        best_found = 1'b1;
        best_c     = 2'(c);
        best_bw    = snap_bw[c];
        pick_cost  = cost_c;
      end
    end
    if (zcnt >= FILL_W'(ZERO_RUN_MIN)) begin
      kind_now = (cmd.open && zcnt == fill) ? DK_ZR_ENTER : DK_ZERO;
    end else if (best_found) begin
      kind_now = DK_BLOCK;
    end else begin
      kind_now = DK_LITERAL;
    end
    lit_k = (fill < FILL_W'(LITERAL_RUN_MAX)) ? fill : FILL_W'(LITERAL_RUN_MAX);
  end

  always_comb begin
    case (dk)
      DK_ZERO:  drop_amt = dz;
      DK_BLOCK: drop_amt = FILL_W'(8) << dci;
      default:  drop_amt = dlit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      dk   <= kind_now;
      dci  <= best_c;
      dbw  <= best_bw;
      dz   <= zcnt;
      dlit <= lit_k;
    end
    if (cmd.item_load) begin
      value_q <= value_in;
    end
  end

  // Window ring pointers and run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      fill  <= '0;
      in_zr <= 1'b0;
      zc    <= '0;
      in_ar <= 1'b0;
      ac    <= '0;
    end else begin
      if (cmd.write) begin
        fill <= fill + FILL_W'(1);
      end else if (cmd.drop) begin
        head <= head + drop_amt[WIN_AW-1:0];
        fill <= fill - drop_amt;
      end else if (cmd.zr_enter) begin
        fill <= '0;
      end
      if (cmd.zr_enter) begin
        in_zr <= 1'b1;
        zc    <= RUN_COUNT_BITS'(zcnt);
      end else if (cmd.zr_clear) begin
        in_zr <= 1'b0;
        zc    <= '0;
      end else if (cmd.zr_inc && zc != '1) begin
        zc <= zc + RUN_COUNT_BITS'(1);
      end
      if (cmd.ar_clear) begin
        in_ar <= 1'b0;
        ac    <= '0;
      end else if (cmd.ar_count) begin
        if (!in_ar) begin
          in_ar <= 1'b1;
          ac    <= RUN_COUNT_BITS'(1);
        end else if (ac != '1) begin
          ac <= ac + RUN_COUNT_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    case (cmd.uleb_src)
      UL_ABSENT: uleb_src_val = (ac != '0) ? 64'(ac - RUN_COUNT_BITS'(1)) : 64'd0;
      UL_ZRUN:   uleb_src_val = (zc != '0) ? 64'(zc - RUN_COUNT_BITS'(1)) : 64'd0;
      UL_ZERO:   uleb_src_val = 64'(dz - FILL_W'(1));
      default:   uleb_src_val = {rdata[62:0], 1'b0} ^ {64{rdata[63]}};
    endcase
  end

  assign bpr_m1 = 3'((1 << dci) - 1);

  always_ff @(posedge clk) begin
    if (cmd.uleb_load) begin
      uleb_q <= uleb_src_val;
    end else if (cmd.push && cmd.byte_src == BS_ULEB) begin
      uleb_q <= {7'd0, uleb_q[63:7]};
    end
    if (cmd.blk_init) begin
      blk_sh <= SH_W'(dbw - BW_W'(1));
      blk_by <= 3'd0;
    end else if (cmd.push && cmd.byte_src == BS_ROW) begin
      if (blk_by == bpr_m1) begin
        blk_by <= 3'd0;
        blk_sh <= blk_sh - SH_W'(1);
      end else begin
        blk_by <= blk_by + 3'd1;
      end
    end
    if (cmd.lit_clear) begin
      li <= '0;
    end else if (cmd.lit_next) begin
      li <= li + FILL_W'(1);
    end
  end

  // Value k of a row sits at bit 0x80 >> (k % 8).
  always_comb begin
    logic [7:0] raw;
    raw = plane[blk_sh][{blk_by, 3'b000} +: 8];
    for (int c = 0; c < 8; c++) begin
      row_byte[7 - c] = raw[c];
    end
  end

  always_comb begin
    case (cmd.byte_src)
      BS_ZERO_RUN: byte_out = BYTE_ZERO_RUN;
      BS_ABSENT:   byte_out = BYTE_ABSENT;
      BS_LITERAL:  byte_out = BYTE_LITERAL;
      BS_BLK_HDR:  byte_out = {1'b0, dci, 5'(dbw - BW_W'(1))};
      BS_LIT_LEN:  byte_out = 8'(dlit - FILL_W'(1));
      BS_ULEB:     byte_out = {|uleb_q[63:7], uleb_q[6:0]};
      BS_ROW:      byte_out = row_byte;
      default:     byte_out = 8'd0;
    endcase
  end

  assign status.fill_zero  = (fill == '0);
  assign status.fill_last  = (fill == FILL_W'(WINDOW_DEPTH - 1));
  assign status.in_zr      = in_zr;
  assign status.in_ar      = in_ar;
  assign status.value_zero = (value_q == 64'd0);
  assign status.scan_done  = (pc == fill);
  assign status.kind       = kind_now;
  assign status.uleb_last  = ~|uleb_q[63:7];
  assign status.blk_last   = (blk_sh == '0) && (blk_by == bpr_m1);
  assign status.lit_done   = (li == dlit);

endmodule

// File: rtl/dbbp_ctrl.sv
// ----------------------------------------------------------------------------
// dbbp_ctrl: sequencing controller
// Walks one observation through run bookkeeping, window decisions, byte
// emission and the final flush of the partial result.
// ----------------------------------------------------------------------------
module dbbp_ctrl
  import dbbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_absent,
  input  logic        item_last,
  output logic        item_ready,
  input  dp_status_t  dp,
  input  asm_status_t asm_st,
  output ctrl_cmd_t   cmd
);

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   it_last, it_last_next;
  logic   open_q, open_next;
  logic   lit_mode, lit_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_OUT;
      it_last  <= 1'b0;
      open_q   <= 1'b0;
      lit_mode <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      it_last  <= it_last_next;
      open_q   <= open_next;
      lit_mode <= lit_mode_next;
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    it_last_next  = it_last;
    open_next     = open_q;
    lit_mode_next = lit_mode;
    cmd           = '0;
    cmd.open      = open_q;
    item_ready    = (state == ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.item_load = 1'b1;
          it_last_next  = item_last;
          phase_next    = item_absent ? PH_ABS : PH_PRES;
          state_next    = ST_DISP;
        end
      end
      ST_DISP: begin
        case (phase)
          PH_ABS: begin
            if (dp.in_zr) begin
              state_next = ST_ZR_HDR;
            end else if (!dp.fill_zero) begin
              cmd.scan_clear = 1'b1;
              open_next      = 1'b0;
              state_next     = ST_SCAN;
            end else begin
              cmd.ar_count = 1'b1;
              phase_next   = PH_LAST;
            end
          end
          PH_PRES: begin
            if (dp.in_ar) begin
              state_next = ST_AR_HDR;
            end else if (dp.in_zr && dp.value_zero) begin
              cmd.zr_inc = 1'b1;
              phase_next = PH_LAST;
            end else if (dp.in_zr) begin
              state_next = ST_ZR_HDR;
            end else begin
              cmd.write  = 1'b1;
              phase_next = PH_LAST;
              if (dp.fill_last) begin
                cmd.scan_clear = 1'b1;
                open_next      = 1'b1;
                state_next     = ST_SCAN;
              end
            end
          end
          PH_LAST: begin
            if (!it_last) begin
              phase_next = PH_OUT;
            end else if (dp.in_zr) begin
              state_next = ST_ZR_HDR;
            end else if (!dp.fill_zero) begin
              cmd.scan_clear = 1'b1;
              open_next      = 1'b0;
              state_next     = ST_SCAN;
            end else if (dp.in_ar) begin
              state_next = ST_AR_HDR;
            end else begin
              phase_next = PH_OUT;
            end
          end
          default: begin
            if (asm_st.flush_ok) begin
              cmd.flush  = 1'b1;
              state_next = ST_IDLE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (dp.scan_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        case (dp.kind)
          DK_ZR_ENTER: begin
            cmd.zr_enter = 1'b1;
            state_next   = ST_DISP;
          end
          DK_ZERO:  state_next = ST_ZERO_HDR;
          DK_BLOCK: state_next = ST_BLK_HDR;
          default:  state_next = ST_LIT_HDR;
        endcase
      end
      ST_ZR_HDR: begin
        cmd.byte_src = BS_ZERO_RUN;
        cmd.uleb_src = UL_ZRUN;
        if (asm_st.byte_ready) begin
          cmd.push      = 1'b1;
          cmd.uleb_load = 1'b1;
          cmd.zr_clear  = 1'b1;
          state_next    = ST_ULEB;
        end
      end
      ST_AR_HDR: begin
        cmd.byte_src = BS_ABSENT;
        cmd.uleb_src = UL_ABSENT;
        if (asm_st.byte_ready) begin
          cmd.push      = 1'b1;
          cmd.uleb_load = 1'b1;
          cmd.ar_clear  = 1'b1;
          state_next    = ST_ULEB;
        end
      end
      ST_ZERO_HDR: begin
        cmd.byte_src = BS_ZERO_RUN;
        cmd.uleb_src = UL_ZERO;
        if (asm_st.byte_ready) begin
          cmd.push      = 1'b1;
          cmd.uleb_load = 1'b1;
          cmd.drop      = 1'b1;
          state_next    = ST_ULEB;
        end
      end
      ST_ULEB: begin
        cmd.byte_src = BS_ULEB;
        if (asm_st.byte_ready) begin
          cmd.push = 1'b1;
          if (dp.uleb_last) begin
            if (lit_mode && !dp.lit_done) begin
              state_next = ST_LIT_RD;
            end else begin
              if (lit_mode) begin
                cmd.drop      = 1'b1;
                lit_mode_next = 1'b0;
              end
              state_next = ST_DISP;
            end
          end
        end
      end
      ST_BLK_HDR: begin
        cmd.byte_src = BS_BLK_HDR;
        if (asm_st.byte_ready) begin
          cmd.push     = 1'b1;
          cmd.blk_init = 1'b1;
          state_next   = ST_BLK_ROW;
        end
      end
      ST_BLK_ROW: begin
        cmd.byte_src = BS_ROW;
        if (asm_st.byte_ready) begin
          cmd.push = 1'b1;
          if (dp.blk_last) begin
            cmd.drop   = 1'b1;
            state_next = ST_DISP;
          end
        end
      end
      ST_LIT_HDR: begin
        cmd.byte_src = BS_LITERAL;
        if (asm_st.byte_ready) begin
          cmd.push      = 1'b1;
          cmd.lit_clear = 1'b1;
          lit_mode_next = 1'b1;
          state_next    = ST_LIT_LEN;
        end
      end
      ST_LIT_LEN: begin
        cmd.byte_src = BS_LIT_LEN;
        if (asm_st.byte_ready) begin
          cmd.push   = 1'b1;
          state_next = ST_LIT_RD;
        end
      end
      ST_LIT_RD: begin
        cmd.rd_lit = 1'b1;
        state_next = ST_LIT_LD;
      end
      ST_LIT_LD: begin
        cmd.uleb_src  = UL_LIT;
        cmd.uleb_load = 1'b1;
        cmd.lit_next  = 1'b1;
        state_next    = ST_ULEB;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
